@@ rtl/ssk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssk_pkg
// Shared types and constants of the Shell sort block: request and status
// codes, the Knuth gap table and the store control bundle.
// ---------------------------------------------------------------------------
package ssk_pkg;

   // field widths
   localparam int DATA_W   = 32;
   localparam int INDEX_W  = 10;
   localparam int GAP_W    = 20;
   localparam int GCNT_W   = 4;
   localparam int STATUS_W = 2;
   localparam int GAP_NUM  = 13;

   // request codes
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   // store port controls
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // gap sequence h = 3h + 1, entry k is the (k+1)-th gap
   function automatic logic [GAP_W-1:0] knuth_gap(input logic [GCNT_W-1:0] k);
      logic [GAP_W-1:0] g;
      case (k)
         4'd0:    g = 20'd1;
         4'd1:    g = 20'd4;
         4'd2:    g = 20'd13;
         4'd3:    g = 20'd40;
         4'd4:    g = 20'd121;
         4'd5:    g = 20'd364;
         4'd6:    g = 20'd1093;
         4'd7:    g = 20'd3280;
         4'd8:    g = 20'd9841;
         4'd9:    g = 20'd29524;
         4'd10:   g = 20'd88573;
         4'd11:   g = 20'd265720;
         4'd12:   g = 20'd797161;
         default: g = 20'd0;
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

@@ rtl/ssk_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssk_req_if
// Request channel: push or read words with valid/ready handshake.
// ---------------------------------------------------------------------------
interface ssk_req_if;
   import ssk_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic signed [DATA_W-1:0]  elem_value;
   logic [INDEX_W-1:0]        read_index;
   logic                      last_elem;

   modport source (output valid, req_type, elem_value, read_index, last_elem,
                   input ready);
   modport sink   (input valid, req_type, elem_value, read_index, last_elem,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/ssk_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssk_rsp_if
// Response channel: one result word per request, valid/ready handshake.
// ---------------------------------------------------------------------------
interface ssk_rsp_if;
   import ssk_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  read_value;
   logic [DATA_W-1:0]         move_count;
   logic [GCNT_W-1:0]         gap_count;
   logic [GAP_W-1:0]          largest_gap;
   logic [STATUS_W-1:0]       status;

   modport source (output valid, read_value, move_count, gap_count, largest_gap,
                   status, input ready);
   modport sink   (input valid, read_value, move_count, gap_count, largest_gap,
                   status, output ready);
endinterface
`default_nettype wire

@@ rtl/ssk_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssk_store
// Element store: one write port and one read port with registered read
// data. Contents are not cleared by reset.
// ---------------------------------------------------------------------------
module ssk_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire                                clock,
   input  ssk_pkg::mem_ctl_type               mem_ctl,
   input  wire [AW-1:0]                       waddr,
   input  wire signed [ssk_pkg::DATA_W-1:0]   wdata,
   input  wire [AW-1:0]                       raddr,
   output logic signed [ssk_pkg::DATA_W-1:0]  rdata
);
   import ssk_pkg::*;

   logic signed [DATA_W-1:0] store_mem [DEPTH];
   logic signed [DATA_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         store_mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rdata_ff <= store_mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ rtl/shell_sort_knuth_gaps_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A push or an out-of-range read registers its response word on acceptance; an
// in-range read passes the store read register, then S_READ. One push per cycle
// while responses drain; a read takes no new request until S_READ is over.
// A last push runs the sort: per gap S_GAP, then per element S_PASS, S_GET_V,
// S_CMP for each compare and S_PLACE, all on the single store read port.
// Reset: synchronous, clears count and control; store contents are kept.
// ---------------------------------------------------------------------------
// shell_sort_knuth_gaps_top
// Shell sort with Knuth gaps over an element store: pushes append words,
// the last push sorts in place by gapped insertion passes, reads return
// stored words by index.
// ---------------------------------------------------------------------------
module shell_sort_knuth_gaps_top #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  wire   clock,
   input  wire   reset,
   ssk_req_if.sink   req_chan,
   ssk_rsp_if.source rsp_chan
);
   import ssk_pkg::*;

   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int EW = (CW > GAP_W) ? CW : GAP_W;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_SETUP, S_GAP, S_PASS, S_GET_V, S_CMP, S_PLACE
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             pos_ff, pos_in;
   logic [CW-1:0]             h_ff, h_in;
   logic [GCNT_W-1:0]         gap_sel_ff, gap_sel_in;
   logic [GCNT_W-1:0]         gap_total_ff, gap_total_in;
   logic [GAP_W-1:0]          largest_ff, largest_in;
   logic signed [DATA_W-1:0]  val_ff, val_in;
   logic [DATA_W-1:0]         moves_ff, moves_in;
   logic                      full_ff, full_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [DATA_W-1:0]         rsp_moves_ff, rsp_moves_in;
   logic [GCNT_W-1:0]         rsp_gaps_ff, rsp_gaps_in;
   logic [GAP_W-1:0]          rsp_big_ff, rsp_big_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;

   mem_ctl_type               mem_ctl;
   logic [AW-1:0]             mem_waddr;
   logic signed [DATA_W-1:0]  mem_wdata;
   logic [AW-1:0]             mem_raddr;
   logic signed [DATA_W-1:0]  mem_rdata;
   logic                      req_fire;

   // element store
   ssk_store #(
      .DEPTH (MAX_ELEMENTS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .raddr   (mem_raddr),
      .rdata   (mem_rdata)
   );

   // handshake: take a word when idle and the response slot is free or draining
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // sequencer next state
   always_comb begin
      logic [CW-1:0]     pos_next;
      logic [GCNT_W-1:0] gap_num;

      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      h_in          = h_ff;
      gap_sel_in    = gap_sel_ff;
      gap_total_in  = gap_total_ff;
      largest_in    = largest_ff;
      val_in        = val_ff;
      moves_in      = moves_ff;
      full_in       = full_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_moves_in  = rsp_moves_ff;
      rsp_gaps_in   = rsp_gaps_ff;
      rsp_big_in    = rsp_big_ff;
      rsp_status_in = rsp_status_ff;
      mem_ctl       = '0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_raddr     = '0;
      pos_next      = pos_ff - h_ff;
      gap_num       = '0;

      case (state_ff)
         // accept push or read
         S_IDLE: begin
            if (req_fire) begin
               rsp_value_in  = '0;
               rsp_moves_in  = '0;
               rsp_gaps_in   = '0;
               rsp_big_in    = '0;
               rsp_status_in = ST_OK;
               if (req_chan.req_type == REQ_PUSH) begin
                  full_in = (count_ff >= CW'(MAX_ELEMENTS));
                  if (count_ff < CW'(MAX_ELEMENTS)) begin
                     mem_ctl.wr_en = 1'b1;
                     mem_waddr     = AW'(count_ff);
                     mem_wdata     = req_chan.elem_value;
                     count_in      = count_ff + 1'b1;
                  end
                  if (req_chan.last_elem) begin
                     moves_in = '0;
                     state_in = S_SETUP;
                  end else begin
                     rsp_status_in = (count_ff >= CW'(MAX_ELEMENTS)) ? ST_FULL : ST_OK;
                     rsp_valid_in  = 1'b1;
                  end
               end else begin
                  if (EW'(req_chan.read_index) < EW'(count_ff)) begin
                     mem_ctl.rd_en = 1'b1;
                     mem_raddr     = AW'(req_chan.read_index);
                     state_in      = S_READ;
                  end else begin
                     rsp_status_in = ST_RANGE;
                     rsp_valid_in  = 1'b1;
                  end
               end
            end
         end

         // read data back from the store
         S_READ: begin
            rsp_value_in = mem_rdata;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         // count the gaps not above the element count
         S_SETUP: begin
            for (int k = 0; k < GAP_NUM; k++) begin
               if (EW'(knuth_gap(GCNT_W'(k))) <= EW'(count_ff)) begin
                  gap_num = gap_num + 1'b1;
               end
            end
            gap_total_in = gap_num;
            gap_sel_in   = gap_num - 1'b1;
            largest_in   = knuth_gap(gap_num - 1'b1);
            state_in     = S_GAP;
         end

         // start a pass at the selected gap
         S_GAP: begin
            h_in     = CW'(knuth_gap(gap_sel_ff));
            idx_in   = CW'(knuth_gap(gap_sel_ff));
            state_in = S_PASS;
         end

         // next element of the pass, or next gap, or done
         S_PASS: begin
            if (idx_ff < count_ff) begin
               mem_ctl.rd_en = 1'b1;
               mem_raddr     = AW'(idx_ff);
               state_in      = S_GET_V;
            end else if (gap_sel_ff == '0) begin
               rsp_value_in  = '0;
               rsp_moves_in  = moves_ff;
               rsp_gaps_in   = gap_total_ff;
               rsp_big_in    = largest_ff;
               rsp_status_in = full_ff ? ST_FULL : ST_OK;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               gap_sel_in = gap_sel_ff - 1'b1;
               state_in   = S_GAP;
            end
         end

         // hold the element being inserted, fetch its gapped neighbor
         S_GET_V: begin
            val_in        = mem_rdata;
            pos_in        = idx_ff;
            mem_ctl.rd_en = 1'b1;
            mem_raddr     = AW'(idx_ff - h_ff);
            state_in      = S_CMP;
         end

         // shift the neighbor up while it is greater
         S_CMP: begin
            if (mem_rdata > val_ff) begin
               mem_ctl.wr_en = 1'b1;
               mem_waddr     = AW'(pos_ff);
               mem_wdata     = mem_rdata;
               pos_in        = pos_next;
               moves_in      = (moves_ff == '1) ? moves_ff : moves_ff + 1'b1;
               if (pos_next >= h_ff) begin
                  mem_ctl.rd_en = 1'b1;
                  mem_raddr     = AW'(pos_next - h_ff);
               end else begin
                  state_in = S_PLACE;
               end
            end else begin
               state_in = S_PLACE;
            end
         end

         // drop the held element into its slot
         S_PLACE: begin
            mem_ctl.wr_en = 1'b1;
            mem_waddr     = AW'(pos_ff);
            mem_wdata     = val_ff;
            idx_in        = idx_ff + 1'b1;
            state_in      = S_PASS;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         moves_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         moves_ff     <= moves_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      h_ff          <= h_in;
      gap_sel_ff    <= gap_sel_in;
      gap_total_ff  <= gap_total_in;
      largest_ff    <= largest_in;
      val_ff        <= val_in;
      full_ff       <= full_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_moves_ff  <= rsp_moves_in;
      rsp_gaps_ff   <= rsp_gaps_in;
      rsp_big_ff    <= rsp_big_in;
      rsp_status_ff <= rsp_status_in;
   end

   // response outputs
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.move_count  = rsp_moves_ff;
   assign rsp_chan.gap_count   = rsp_gaps_ff;
   assign rsp_chan.largest_gap = rsp_big_ff;
   assign rsp_chan.status      = rsp_status_ff;

`ifndef ASSERT_OFF
   // element count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ELEMENTS))
      else $error("element count beyond store depth");

   // a shift never writes the entry being read in the same cycle
   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (mem_ctl.wr_en && mem_ctl.rd_en) |-> (mem_waddr != mem_raddr))
      else $error("store read and write hit the same entry");

   // the compared neighbor lies one gap below the insert position
   a_pos_gap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (pos_ff >= h_ff))
      else $error("insert position below gap");

   // a sort always ends in a response
   a_sort_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PASS && state_in == S_IDLE) |=> rsp_valid_ff)
      else $error("sort finished without a response");
`endif

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Bench for the Knuth-gap Shell sort block. A short table of pushes and reads
// covers the empty store, reads before a sort, value extremes and range
// errors. Random sessions follow: pushes closed by a last push, then reads.
// The sessions run until the store is full and the word target is met, going
// on with reads and pushes while full. Every response word is checked against the
// table's typed response or an in-bench sort model. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;
   import ssk_pkg::*;

   localparam int STORE_DEPTH  = 1024;
   localparam int WORD_TARGET  = 1600;
   localparam int FULL_SORTS   = 6;
   localparam int DRAIN_CYCLES = 50;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic                     req_type;
      logic signed [DATA_W-1:0] elem_value;
      logic [INDEX_W-1:0]       read_index;
      logic                     last_elem;
   } req_word_t;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [DATA_W-1:0]        move_count;
      logic [GCNT_W-1:0]        gap_count;
      logic [GAP_W-1:0]         largest_gap;
      logic [STATUS_W-1:0]      status;
   } rsp_word_t;

   // one directed row: request, then the typed response where it is obvious
   typedef struct packed {
      req_word_t req;
      logic      typed;
      rsp_word_t rsp;
   } dir_row_t;

   localparam dir_row_t DIRECTED_ROWS [19] = '{
      // read of the empty store
      '{'{REQ_READ, 32'sh0000_0000, 10'd0, 1'b0},    1'b1, '{32'sd0, 32'd0, 4'd0, 20'd0, ST_RANGE}},
      // single element sort
      '{'{REQ_PUSH, 32'sh7FFF_FFFF, 10'd0, 1'b1},    1'b1, '{32'sd0, 32'd0, 4'd1, 20'd1, ST_OK}},
      '{'{REQ_PUSH, 32'sh8000_0000, 10'd1023, 1'b0}, 1'b1, '{32'sd0, 32'd0, 4'd0, 20'd0, ST_OK}},
      '{'{REQ_PUSH, 32'sh0000_0000, 10'd0, 1'b0},    1'b1, '{32'sd0, 32'd0, 4'd0, 20'd0, ST_OK}},
      // reads before the next sort see push order; last is ignored on a read
      '{'{REQ_READ, 32'shFFFF_FFFF, 10'd0, 1'b1},    1'b1,
        '{32'sh7FFF_FFFF, 32'd0, 4'd0, 20'd0, ST_OK}},
      '{'{REQ_READ, 32'sh0000_0000, 10'd1, 1'b0},    1'b1,
        '{32'sh8000_0000, 32'd0, 4'd0, 20'd0, ST_OK}},
      '{'{REQ_READ, 32'sh0000_0000, 10'd2, 1'b0},    1'b1, '{32'sd0, 32'd0, 4'd0, 20'd0, ST_OK}},
      '{'{REQ_READ, 32'sh0000_0000, 10'd3, 1'b0},    1'b1, '{32'sd0, 32'd0, 4'd0, 20'd0, ST_RANGE}},
      '{'{REQ_READ, 32'sh0000_0000, 10'd1023, 1'b0}, 1'b1, '{32'sd0, 32'd0, 4'd0, 20'd0, ST_RANGE}},
      // sort of four with both extremes
      '{'{REQ_PUSH, 32'shFFFF_FFFF, 10'd0, 1'b1},    1'b0, '0},
      '{'{REQ_READ, 32'sh0000_0000, 10'd0, 1'b0},    1'b0, '0},
      '{'{REQ_READ, 32'sh0000_0000, 10'd1, 1'b0},    1'b0, '0},
      '{'{REQ_READ, 32'sh0000_0000, 10'd2, 1'b0},    1'b0, '0},
      '{'{REQ_READ, 32'sh0000_0000, 10'd3, 1'b0},    1'b0, '0},
      // pushes after a sort append to the sorted words
      '{'{REQ_PUSH, 32'sh5A5A_A5A5, 10'd0, 1'b0},    1'b1, '{32'sd0, 32'd0, 4'd0, 20'd0, ST_OK}},
      '{'{REQ_PUSH, 32'sh1234_5678, 10'd682, 1'b1},  1'b0, '0},
      '{'{REQ_READ, 32'sh0000_0000, 10'd5, 1'b0},    1'b0, '0},
      '{'{REQ_READ, 32'sh0000_0000, 10'd6, 1'b0},    1'b1, '{32'sd0, 32'd0, 4'd0, 20'd0, ST_RANGE}},
      '{'{REQ_READ, 32'sh0000_0000, 10'd512, 1'b0},  1'b1, '{32'sd0, 32'd0, 4'd0, 20'd0, ST_RANGE}}
   };

   logic clock;
   logic reset;

   ssk_req_if req_chan ();
   ssk_rsp_if rsp_chan ();

   shell_sort_knuth_gaps_top #(
      .MAX_ELEMENTS (STORE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // sort model state
   logic signed [DATA_W-1:0] model_store [STORE_DEPTH];
   int unsigned              model_count;

   rsp_word_t pending_rsp [$];
   int        words_sent;
   int        error_count;
   bit        quiet_tx;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #(12 * 100_000_000);
      $display("tb_top: errors");
      $finish;
   end

   // idle length: mostly none, some short, a few long
   function automatic int pause_len(input bit quiet);
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 60)
         return 0;
      else if (pick < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // element values: extremes, a narrow band for duplicates, or anything
   function automatic logic signed [DATA_W-1:0] pick_value();
      int pick;
      pick = $urandom_range(0, 7);
      case (pick)
         0: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh8000_0000;
               1:       return 32'sh7FFF_FFFF;
               2:       return 32'sh0000_0000;
               default: return 32'shFFFF_FFFF;
            endcase
         end
         1, 2: return $signed($urandom_range(0, 15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   // gapped insertion passes, largest Knuth gap not above the count first
   function automatic void knuth_sort(output logic [DATA_W-1:0] moves,
                                      output logic [GCNT_W-1:0] gaps,
                                      output logic [GAP_W-1:0] first);
      int unsigned              h;
      int unsigned              n;
      int unsigned              step;
      int unsigned              pos;
      logic signed [DATA_W-1:0] v;
      logic [DATA_W-1:0]        shifts;
      h = 1;
      n = 1;
      shifts = '0;
      while (3 * h + 1 <= model_count) begin
         h = 3 * h + 1;
         n++;
      end
      gaps = GCNT_W'(n);
      first = GAP_W'(h);
      step = h;
      // a step of 1 maps to 0, which ends the passes
      while (step != 0) begin
         for (int unsigned i = step; i < model_count; i++) begin
            v = model_store[i];
            pos = i;
            while (pos >= step && model_store[pos - step] > v) begin
               model_store[pos] = model_store[pos - step];
               pos -= step;
               if (shifts != 32'hFFFF_FFFF)
                  shifts++;
            end
            model_store[pos] = v;
         end
         step = (step - 1) / 3;
      end
      moves = shifts;
   endfunction

   // update the model with one accepted word and return its response
   function automatic rsp_word_t apply_request(input req_word_t w);
      rsp_word_t r;
      r = '0;
      if (w.req_type == REQ_PUSH) begin
         if (model_count < STORE_DEPTH) begin
            model_store[model_count] = w.elem_value;
            model_count++;
         end else begin
            r.status = ST_FULL;
         end
         if (w.last_elem)
            knuth_sort(r.move_count, r.gap_count, r.largest_gap);
      end else if (w.read_index < model_count) begin
         r.read_value = model_store[w.read_index];
      end else begin
         r.status = ST_RANGE;
      end
      return r;
   endfunction

   // drive one request word and hold it until the handshake
   task automatic send_word(input req_word_t w, input bit typed, input rsp_word_t typed_rsp);
      int        gap;
      rsp_word_t pred;
      gap = pause_len(quiet_tx);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= w.req_type;
      req_chan.elem_value <= w.elem_value;
      req_chan.read_index <= w.read_index;
      req_chan.last_elem  <= w.last_elem;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      pred = apply_request(w);
      pending_rsp.push_back(typed ? typed_rsp : pred);
      words_sent++;
   endtask

   // read word: mostly in range, sometimes past the count
   task automatic send_read();
      req_word_t w;
      w.req_type   = REQ_READ;
      w.elem_value = pick_value();
      w.last_elem  = 1'($urandom_range(0, 1));
      if (model_count > 0 && (model_count == STORE_DEPTH || $urandom_range(0, 7) != 0))
         w.read_index = INDEX_W'($urandom_range(0, model_count - 1));
      else
         w.read_index = INDEX_W'($urandom_range(model_count, STORE_DEPTH - 1));
      send_word(w, 1'b0, '0);
   endtask

   task automatic send_push(input logic last);
      req_word_t w;
      w.req_type   = REQ_PUSH;
      w.elem_value = pick_value();
      w.read_index = INDEX_W'($urandom_range(0, STORE_DEPTH - 1));
      w.last_elem  = last;
      send_word(w, 1'b0, '0);
   endtask

   // hold off the sender until every pending response is back
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
   endtask

   // response side: random stalls, with quiet stretches
   initial begin : rsp_ready_drive
      int  stall;
      bit  quiet_rx;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         quiet_rx = ($urandom_range(0, 3) == 0);
         stall = pause_len(quiet_rx);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat (quiet_rx ? $urandom_range(20, 60) : $urandom_range(1, 12)) @(posedge clock);
      end
   end

   // compare each accepted response word with the oldest pending one
   always @(posedge clock) begin : check_rsp
      rsp_word_t got;
      rsp_word_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.read_value  = rsp_chan.read_value;
         got.move_count  = rsp_chan.move_count;
         got.gap_count   = rsp_chan.gap_count;
         got.largest_gap = rsp_chan.largest_gap;
         got.status      = rsp_chan.status;
         if (pending_rsp.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: response word with nothing pending: value %0d status %0d",
                        $realtime, got.read_value, got.status);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"%0t: mismatch value %0d/%0d moves %0d/%0d gaps %0d/%0d ",
                            "first %0d/%0d status %0d/%0d (expected/actual)"},
                           $realtime, want.read_value, got.read_value,
                           want.move_count, got.move_count, want.gap_count, got.gap_count,
                           want.largest_gap, got.largest_gap, want.status, got.status);
            end
         end
      end
   end

   initial begin : stimulus
      req_word_t w;
      rsp_word_t typed_rsp;
      int        n_push;
      int        n_read;
      int        full_pushes;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.req_type   = REQ_PUSH;
      req_chan.elem_value = '0;
      req_chan.read_index = '0;
      req_chan.last_elem  = 1'b0;
      model_count = 0;
      words_sent  = 0;
      error_count = 0;
      quiet_tx    = 1'b0;
      full_pushes = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         w = DIRECTED_ROWS[i].req;
         typed_rsp = DIRECTED_ROWS[i].rsp;
         send_word(w, DIRECTED_ROWS[i].typed, typed_rsp);
      end
      drain_responses();

      // random sessions: pushes closed by a last push, then reads
      while (words_sent < WORD_TARGET || model_count < STORE_DEPTH) begin
         quiet_tx = ($urandom_range(0, 3) == 0);
         if (model_count < STORE_DEPTH) begin
            n_push = $urandom_range(1, 48);
            for (int k = 1; k <= n_push; k++) begin
               send_push(k == n_push || $urandom_range(0, 63) == 0);
               if ($urandom_range(0, 15) == 0)
                  send_read();
            end
         end else begin
            // store full: pushes are dropped, a few still sort
            full_pushes++;
            send_push(full_pushes % 4 == 2 && full_pushes / 4 < FULL_SORTS);
         end
         n_read = $urandom_range(2, 12);
         repeat (n_read) send_read();
         if ($urandom_range(0, 4) == 0)
            drain_responses();
      end

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
